// ----- src/ppid_pkg.sv -----
package ppid_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int OPND_W  = 18;
    localparam int PROD_W  = 36;
    localparam int SUM_W   = 35;
    localparam int MAG_W   = 33;
    localparam int CSQ_W   = 66;
    localparam int DIST_W  = 17;
    localparam logic [DIST_W-1:0] DIST_SAT = 17'h1FFFF;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_CSQ,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

endpackage

// ----- src/ppid_if.sv -----
interface ppid_in_if;
    import ppid_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic                       closes_polygon;
    modport source (output valid, mode, coord_x, coord_y, closes_polygon, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, closes_polygon, output ready);
endinterface

interface ppid_out_if;
    import ppid_pkg::*;
    logic                valid;
    logic                ready;
    logic                inside_res;
    logic [DIST_W-1:0]   distance;
    logic                no_edges;
    logic                status;
    modport source (output valid, inside_res, distance, no_edges, status, input ready);
    modport sink   (input valid, inside_res, distance, no_edges, status, output ready);
endinterface

// ----- src/ppid_mul.sv -----
module ppid_mul
    import ppid_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [OPND_W-1:0]  i_a,
    input  logic signed [OPND_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- src/ppid_divsqrt.sv -----
module ppid_divsqrt
    import ppid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_iter_ctl          i_ctl,
    input  logic [CSQ_W-1:0]   i_num,
    input  logic [MAG_W-1:0]   i_den,
    output t_iter_sts          o_sts,
    output logic [MAG_W-1:0]   o_res
);

    localparam logic [5:0] DIV_STEPS  = 6'd33;
    localparam logic [5:0] SQRT_STEPS = 6'd17;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    t_op               r_op, n_op;
    logic [5:0]        r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_rem, n_rem;
    logic [MAG_W-1:0]  r_den, n_den;
    logic [18:0]       r_srem, n_srem;
    logic [33:0]       r_sh, n_sh;
    logic [16:0]       r_root, n_root;

    logic [33:0]       div_t;
    logic              div_ge;
    logic [20:0]       sq_t;
    logic [20:0]       sq_trial;
    logic              sq_ge;

    // one quotient bit or one root bit per cycle
    always_comb begin
        div_t    = {r_rem, r_sh[32]};
        div_ge   = div_t >= {1'b0, r_den};
        sq_t     = {r_srem, r_sh[33:32]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = sq_t >= sq_trial;

        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_srem = r_srem;
        n_sh   = r_sh;
        n_root = r_root;

        if (i_ctl.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_den  = i_den;
            n_rem  = i_num[CSQ_W-1:MAG_W];
            n_sh   = {1'b0, i_num[MAG_W-1:0]};
            n_srem = '0;
            n_root = '0;
            n_cnt  = (i_ctl.op == OP_DIV) ? DIV_STEPS : SQRT_STEPS;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                n_rem = div_ge ? 33'(div_t - {1'b0, r_den}) : div_t[32:0];
                n_sh  = {1'b0, r_sh[31:0], div_ge};
            end else begin
                n_srem = sq_ge ? 19'(sq_t - sq_trial) : sq_t[18:0];
                n_root = {r_root[15:0], sq_ge};
                n_sh   = {r_sh[31:0], 2'b00};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_srem <= n_srem;
        r_sh   <= n_sh;
        r_root <= n_root;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res = (r_op == OP_DIV) ? r_sh[MAG_W-1:0] : {16'd0, r_root};

endmodule

// ----- src/polygon_point_inside_and_distance.sv -----
// clear and append: result registered in the cycle after the transaction is taken
// query: walks the stored vertices in order, running each edge through the multiplier,
//   then the root (closest point at an end vertex) or divider and root (perpendicular foot)
// one transaction at a time: next one taken at the earliest in the cycle its result leaves
// reset is synchronous, active low: clears vertex count, sequencer and output valid;
//   the vertex store itself is not cleared
module polygon_point_inside_and_distance
    import ppid_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppid_in_if.sink    i_in,
    ppid_out_if.source o_out
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // vertex store
    logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
    logic                      mem_m [MAX_VERTICES];
    logic signed [COORD_W-1:0] r_vx, r_vy;
    logic                      r_vm;
    logic                      mem_we;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_k, n_k;
    logic                      r_pend, n_pend;
    logic                      r_cend, n_cend;
    logic                      r_closing, n_closing;
    logic [3:0]                r_step, n_step;
    logic signed [COORD_W-1:0] r_px, n_px, r_py, n_py;
    logic signed [COORD_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [COORD_W-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [COORD_W-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    t_sum                      r_len2, n_len2, r_dot, n_dot, r_ap2, n_ap2;
    t_sum                      r_bp2, n_bp2, r_cr, n_cr, r_m11, n_m11;
    logic [CSQ_W-1:0]          r_c2, n_c2;
    logic                      r_par, n_par, r_inside, n_inside, r_any, n_any;
    logic [DIST_W-1:0]         r_best, n_best;

    logic                      r_ov, n_ov;
    logic                      r_o_inside, n_o_inside;
    logic [DIST_W-1:0]         r_o_dist, n_o_dist;
    logic                      r_o_noedge, n_o_noedge;
    logic                      r_o_status, n_o_status;

    logic signed [DIFF_W-1:0]  abx, aby, apx, apy, bpx, bpy;
    logic signed [OPND_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    t_sum                      psum;
    t_sum                      cabs;
    logic [OPND_W-1:0]         c_hi, c_lo;
    logic                      in_acc, out_free, vlast, crossing, advance;
    logic [DIST_W-1:0]         dres;

    t_iter_ctl                 it_ctl;
    t_iter_sts                 it_sts;
    logic [CSQ_W-1:0]          it_num;
    logic [MAG_W-1:0]          it_res;

    ppid_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ppid_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (it_ctl),
        .i_num   (it_num),
        .i_den   (r_len2[MAG_W-1:0]),
        .o_sts   (it_sts),
        .o_res   (it_res)
    );

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[r_count[AW-1:0]] <= i_in.coord_x;
            mem_y[r_count[AW-1:0]] <= i_in.coord_y;
            mem_m[r_count[AW-1:0]] <= i_in.closes_polygon;
        end
        r_vx <= mem_x[r_k[AW-1:0]];
        r_vy <= mem_y[r_k[AW-1:0]];
        r_vm <= mem_m[r_k[AW-1:0]];
    end

    // edge differences, product slice, cross product magnitude split and crossing flag
    always_comb begin
        abx  = DIFF_W'(r_bx) - DIFF_W'(r_ax);
        aby  = DIFF_W'(r_by) - DIFF_W'(r_ay);
        apx  = DIFF_W'(r_px) - DIFF_W'(r_ax);
        apy  = DIFF_W'(r_py) - DIFF_W'(r_ay);
        bpx  = DIFF_W'(r_px) - DIFF_W'(r_bx);
        bpy  = DIFF_W'(r_py) - DIFF_W'(r_by);
        psum = prod[SUM_W-1:0];
        cabs = (r_cr < 0) ? -r_cr : r_cr;
        c_hi = {2'b00, cabs[32:17]};
        c_lo = {1'b0, cabs[16:0]};
        crossing = (r_ay > r_py) != (r_by > r_py);
        dres = it_res[DIST_W-1:0];
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                4'd0:  begin mul_a = OPND_W'(abx); mul_b = OPND_W'(abx); end
                4'd1:  begin mul_a = OPND_W'(aby); mul_b = OPND_W'(aby); end
                4'd2:  begin mul_a = OPND_W'(apx); mul_b = OPND_W'(abx); end
                4'd3:  begin mul_a = OPND_W'(apy); mul_b = OPND_W'(aby); end
                4'd4:  begin mul_a = OPND_W'(apx); mul_b = OPND_W'(apx); end
                4'd5:  begin mul_a = OPND_W'(apy); mul_b = OPND_W'(apy); end
                4'd6:  begin mul_a = OPND_W'(bpx); mul_b = OPND_W'(bpx); end
                4'd7:  begin mul_a = OPND_W'(bpy); mul_b = OPND_W'(bpy); end
                4'd8:  begin mul_a = OPND_W'(apx); mul_b = OPND_W'(aby); end
                4'd9:  begin mul_a = OPND_W'(apy); mul_b = OPND_W'(abx); end
                4'd10: begin mul_a = OPND_W'(bpx); mul_b = OPND_W'(aby); end
                4'd11: begin mul_a = OPND_W'(abx); mul_b = OPND_W'(bpy); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_CSQ) begin
            case (r_step)
                4'd0:    begin mul_a = c_hi; mul_b = c_hi; end
                4'd1:    begin mul_a = c_hi; mul_b = c_lo; end
                4'd2:    begin mul_a = c_lo; mul_b = c_lo; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;   n_count = r_count;   n_k = r_k;
        n_pend = r_pend;     n_cend = r_cend;     n_closing = r_closing;
        n_step = r_step;     n_px = r_px;         n_py = r_py;
        n_prev_x = r_prev_x; n_prev_y = r_prev_y;
        n_first_x = r_first_x; n_first_y = r_first_y;
        n_ax = r_ax; n_ay = r_ay; n_bx = r_bx; n_by = r_by;
        n_len2 = r_len2; n_dot = r_dot; n_ap2 = r_ap2; n_bp2 = r_bp2;
        n_cr = r_cr; n_m11 = r_m11; n_c2 = r_c2;
        n_par = r_par; n_inside = r_inside; n_any = r_any; n_best = r_best;
        n_ov = r_ov; n_o_inside = r_o_inside; n_o_dist = r_o_dist;
        n_o_noedge = r_o_noedge; n_o_status = r_o_status;
        it_ctl.start = 1'b0;
        it_ctl.op    = OP_DIV;
        it_num       = r_c2;
        mem_we       = 1'b0;
        advance      = 1'b0;

        out_free   = !r_ov || o_out.ready;
        in_acc     = i_in.valid && i_in.ready;
        vlast      = r_vm || (r_k + CW'(1) == r_count);

        if (o_out.valid && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ov = 1'b1;
                    n_o_inside = 1'b0;
                    n_o_dist = '0;
                    n_o_noedge = 1'b0;
                    n_o_status = 1'b0;
                    case (i_in.mode)
                        MODE_CLEAR: n_count = '0;
                        MODE_APPEND: begin
                            if (r_count == CW'(MAX_VERTICES)) begin
                                n_o_status = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_QUERY: begin
                            n_ov     = 1'b0;
                            n_px     = i_in.coord_x;
                            n_py     = i_in.coord_y;
                            n_inside = 1'b0;
                            n_any    = 1'b0;
                            n_best   = DIST_SAT;
                            n_par    = 1'b0;
                            n_pend   = 1'b1;
                            n_closing = 1'b0;
                            n_k      = '0;
                            n_state  = (r_count == '0) ? S_DONE : S_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD: begin
                if (r_pend) begin
                    n_first_x = r_vx; n_first_y = r_vy;
                    n_prev_x  = r_vx; n_prev_y  = r_vy;
                    if (vlast) begin
                        advance = 1'b1;
                    end else begin
                        n_pend  = 1'b0;
                        advance = 1'b1;
                    end
                end else begin
                    n_ax = r_prev_x; n_ay = r_prev_y;
                    n_bx = r_vx;     n_by = r_vy;
                    n_prev_x = r_vx; n_prev_y = r_vy;
                    n_cend = vlast;
                    n_closing = 1'b0;
                    n_step = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd1:  n_len2 = psum;
                    4'd2:  n_len2 = r_len2 + psum;
                    4'd3:  n_dot  = psum;
                    4'd4:  n_dot  = r_dot + psum;
                    4'd5:  n_ap2  = psum;
                    4'd6:  n_ap2  = r_ap2 + psum;
                    4'd7:  n_bp2  = psum;
                    4'd8:  n_bp2  = r_bp2 + psum;
                    4'd9:  n_cr   = psum;
                    4'd10: n_cr   = r_cr - psum;
                    4'd11: n_m11  = psum;
                    4'd12: begin
                        // ray crossing test and choice of closest point
                        if (crossing && ((aby < 0) ? (r_m11 > psum) : (r_m11 < psum))) begin
                            n_par = !r_par;
                        end
                        n_step = '0;
                        if (r_dot <= 0) begin
                            it_ctl.start = 1'b1;
                            it_ctl.op    = OP_SQRT;
                            it_num       = CSQ_W'(r_ap2[MAG_W-1:0]);
                            n_state      = S_SQRT;
                        end else if (r_dot >= r_len2) begin
                            it_ctl.start = 1'b1;
                            it_ctl.op    = OP_SQRT;
                            it_num       = CSQ_W'(r_bp2[MAG_W-1:0]);
                            n_state      = S_SQRT;
                        end else begin
                            n_state = S_CSQ;
                        end
                    end
                    default: ;
                endcase
            end
            S_CSQ: begin
                // cross product squared from three partial products
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd1: n_c2 = CSQ_W'(prod[33:0]) << 34;
                    4'd2: n_c2 = r_c2 + (CSQ_W'(prod[33:0]) << 18);
                    4'd3: n_c2 = r_c2 + CSQ_W'(prod[33:0]);
                    4'd4: begin
                        it_ctl.start = 1'b1;
                        it_ctl.op    = OP_DIV;
                        it_num       = r_c2;
                        n_step       = '0;
                        n_state      = S_DIV;
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                if (it_sts.done) begin
                    it_ctl.start = 1'b1;
                    it_ctl.op    = OP_SQRT;
                    it_num       = CSQ_W'(it_res);
                    n_state      = S_SQRT;
                end
            end
            S_SQRT: begin
                if (it_sts.done) begin
                    n_any = 1'b1;
                    if (dres < r_best) begin
                        n_best = dres;
                    end
                    if (!r_closing && r_cend) begin
                        // closing edge from last vertex back to first
                        n_ax = r_prev_x;  n_ay = r_prev_y;
                        n_bx = r_first_x; n_by = r_first_y;
                        n_closing = 1'b1;
                        n_step = '0;
                        n_state = S_MUL;
                    end else begin
                        if (r_closing) begin
                            n_inside  = r_inside | r_par;
                            n_par     = 1'b0;
                            n_pend    = 1'b1;
                            n_closing = 1'b0;
                        end
                        advance = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_inside = r_inside;
                    n_o_dist   = r_any ? r_best : DIST_SAT;
                    n_o_noedge = !r_any;
                    n_o_status = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next stored vertex, or to done after the last one
        if (advance) begin
            if (r_k + CW'(1) == r_count) begin
                n_state = S_DONE;
            end else begin
                n_k = r_k + CW'(1);
                n_state = S_FETCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;           r_pend <= n_pend;     r_cend <= n_cend;
        r_closing <= n_closing; r_step <= n_step;
        r_px <= n_px;         r_py <= n_py;
        r_prev_x <= n_prev_x; r_prev_y <= n_prev_y;
        r_first_x <= n_first_x; r_first_y <= n_first_y;
        r_ax <= n_ax; r_ay <= n_ay; r_bx <= n_bx; r_by <= n_by;
        r_len2 <= n_len2; r_dot <= n_dot; r_ap2 <= n_ap2; r_bp2 <= n_bp2;
        r_cr <= n_cr; r_m11 <= n_m11; r_c2 <= n_c2;
        r_par <= n_par; r_inside <= n_inside; r_any <= n_any; r_best <= n_best;
        r_o_inside <= n_o_inside; r_o_dist <= n_o_dist;
        r_o_noedge <= n_o_noedge; r_o_status <= n_o_status;
    end

    assign i_in.ready       = (r_state == S_IDLE) && (!r_ov || o_out.ready);
    assign o_out.valid      = r_ov;
    assign o_out.inside_res = r_o_inside;
    assign o_out.distance   = r_o_dist;
    assign o_out.no_edges   = r_o_noedge;
    assign o_out.status     = r_o_status;

    // checks
    a_noedge_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_edges) |-> (o_out.distance == DIST_SAT))
        else $error("no_edges without saturated distance");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("ready while query in progress");

    a_unit_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        it_ctl.start |-> !it_sts.busy)
        else $error("divide/root unit started while busy");

endmodule
